// ===== rtl/lfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types and constants of the length-prefixed frame parser: frame
// layout, register indexes, verdict codes, queue entry and output packing.
// ----------------------------------------------------------------------------
package lfp_pkg;

	// frame layout
	localparam int unsigned LEN_BYTES    = 4;
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned PAY_START    = LEN_BYTES + HEADER_BYTES;

	// saturating position counter
	localparam int unsigned CNT_W = 25;

	// front-to-back queue
	localparam int unsigned QUEUE_DEPTH = 2;

	// configuration port
	localparam int unsigned CFG_W = 32;
	localparam int unsigned IDX_W = 2;

	// output tdata: payload_byte, error_code, frame_type, frame_flags,
	// request_number, header_status, payload_count
	localparam int unsigned FIELDS_W = 8 + 3 + 16 + 16 + 32 + 32 + 24;
	localparam int unsigned TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
	localparam int unsigned PAD_W    = TDATA_W - FIELDS_W;

	typedef enum logic [IDX_W-1:0] {
		REG_VERSION   = 2'd0,
		REG_RESP_MASK = 2'd1,
		REG_LEN_CAP   = 2'd2
	} lfp_reg_e;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_OVER_CAP  = 3'd2,
		ERR_MISMATCH  = 3'd3,
		ERR_NO_HEADER = 3'd4,
		ERR_VERSION   = 3'd5,
		ERR_ID_ZERO   = 3'd6,
		ERR_STATUS    = 3'd7
	} lfp_err_e;

	typedef struct packed {
		logic [31:0] expected_version;
		logic [15:0] response_mask;
		logic [23:0] length_cap;
	} lfp_cfg_t;

	// one classified byte on its way from the front to the back
	typedef struct packed {
		logic [7:0]  data;
		logic        pay;
		logic        last;
		logic        short_frame;
		logic        mismatch;
		logic [31:0] body_length;
		logic [15:0] frame_type;
		logic [15:0] frame_flags;
		logic [31:0] request_number;
		logic [31:0] header_status;
		logic [31:0] version;
	} lfp_entry_t;

endpackage
`default_nettype wire

// ===== rtl/lfp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_front
// Accepts frame bytes, tracks the position, captures length and header and
// pushes one classified entry per payload or final byte.
// ----------------------------------------------------------------------------
module lfp_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire  [7:0]         s_tdata,
	input  wire                s_tlast,
	input  wire                q_full,
	output logic               q_push,
	output lfp_pkg::lfp_entry_t q_entry
);
	import lfp_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      body_q, body_n;
	logic [15:0]      type_q, type_n;
	logic [15:0]      flags_q, flags_n;
	logic [31:0]      req_q, req_n;
	logic [31:0]      status_q, status_n;
	logic [31:0]      ver_q, ver_n;
	logic [4:0]       hdr_idx;
	logic             pos_zero;
	logic             pay;
	logic             accept;
	logic [32:0]      size_cnt;
	logic [32:0]      size_exp;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign pos_zero = (cnt_q == '0);
	assign pay      = (cnt_q >= CNT_W'(PAY_START));
	assign hdr_idx  = 5'(cnt_q[4:0] - 5'(LEN_BYTES));

	always_comb begin
		body_n   = pos_zero ? '0 : body_q;
		type_n   = pos_zero ? '0 : type_q;
		flags_n  = pos_zero ? '0 : flags_q;
		req_n    = pos_zero ? '0 : req_q;
		status_n = pos_zero ? '0 : status_q;
		ver_n    = pos_zero ? '0 : ver_q;
		if (cnt_q < CNT_W'(LEN_BYTES)) begin
			body_n[{cnt_q[1:0], 3'b000} +: 8] = s_tdata;
		end else if (cnt_q < CNT_W'(PAY_START)) begin
			case (hdr_idx[3:2])
				2'd0: begin
					if (!hdr_idx[1]) begin
						type_n[{hdr_idx[0], 3'b000} +: 8] = s_tdata;
					end else begin
						flags_n[{hdr_idx[0], 3'b000} +: 8] = s_tdata;
					end
				end
				2'd1: req_n[{hdr_idx[1:0], 3'b000} +: 8]    = s_tdata;
				2'd2: status_n[{hdr_idx[1:0], 3'b000} +: 8] = s_tdata;
				default: ver_n[{hdr_idx[1:0], 3'b000} +: 8] = s_tdata;
			endcase
		end
	end

	// frame size so far against the size the length prefix promises
	assign size_cnt = {{(33-CNT_W){1'b0}}, cnt_q} + 33'd1;
	assign size_exp = {1'b0, body_n} + 33'(LEN_BYTES);

	assign q_push = accept && (pay || s_tlast);

	always_comb begin
		q_entry.data           = s_tdata;
		q_entry.pay            = pay;
		q_entry.last           = s_tlast;
		q_entry.short_frame    = (cnt_q < CNT_W'(LEN_BYTES - 1));
		q_entry.mismatch       = (size_cnt != size_exp);
		q_entry.body_length    = body_n;
		q_entry.frame_type     = type_n;
		q_entry.frame_flags    = flags_n;
		q_entry.request_number = req_n;
		q_entry.header_status  = status_n;
		q_entry.version        = ver_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			body_q   <= '0;
			type_q   <= '0;
			flags_q  <= '0;
			req_q    <= '0;
			status_q <= '0;
			ver_q    <= '0;
		end else if (accept) begin
			body_q   <= body_n;
			type_q   <= type_n;
			flags_q  <= flags_n;
			req_q    <= req_n;
			status_q <= status_n;
			ver_q    <= ver_n;
			if (s_tlast) begin
				cnt_q <= '0;
			end else if (cnt_q != '1) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> cnt_q == '0)
		else $error("position not rewound after final byte");
`endif

endmodule
`default_nettype wire

// ===== rtl/lfp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module lfp_queue #(
	parameter int unsigned DEPTH = lfp_pkg::QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lfp_pkg::lfp_entry_t entry_in,
	output logic                full,
	input  wire                 pop,
	output logic                valid,
	output lfp_pkg::lfp_entry_t entry_out
);
	import lfp_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	lfp_entry_t       entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign valid     = (count_q != '0);
	assign entry_out = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/lfp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_back
// Pops classified entries, works out the verdict on final bytes and holds
// each result in the output register until it is taken.
// ----------------------------------------------------------------------------
module lfp_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  lfp_pkg::lfp_cfg_t                cfg,
	input  wire                              q_valid,
	input  lfp_pkg::lfp_entry_t              q_entry,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [lfp_pkg::TDATA_W-1:0]      m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import lfp_pkg::*;

	lfp_err_e             err;
	logic                 resp_frame;
	logic [31:0]          body_diff;
	logic [23:0]          count_n;
	logic [7:0]           byte_n;
	logic [TDATA_W-1:0]   tdata_n;
	logic                 out_valid_q;
	logic [TDATA_W-1:0]   out_data_q;
	logic                 out_user_q;
	logic                 out_last_q;

	assign resp_frame = ((q_entry.frame_flags & cfg.response_mask) != '0);
	assign body_diff  = q_entry.body_length - 32'(HEADER_BYTES);

	// checks in priority order, first failure wins
	always_comb begin
		if (q_entry.short_frame) begin
			err = ERR_SHORT;
		end else if (q_entry.body_length > {8'b0, cfg.length_cap}) begin
			err = ERR_OVER_CAP;
		end else if (q_entry.mismatch) begin
			err = ERR_MISMATCH;
		end else if (q_entry.body_length < 32'(HEADER_BYTES)) begin
			err = ERR_NO_HEADER;
		end else if (q_entry.version != cfg.expected_version) begin
			err = ERR_VERSION;
		end else if (!resp_frame && q_entry.request_number == '0) begin
			err = ERR_ID_ZERO;
		end else if (!resp_frame && q_entry.header_status != '0) begin
			err = ERR_STATUS;
		end else begin
			err = ERR_OK;
		end
	end

	always_comb begin
		byte_n = q_entry.pay ? q_entry.data : 8'd0;
		if (err == ERR_SHORT || err == ERR_OVER_CAP || err == ERR_MISMATCH ||
		    err == ERR_NO_HEADER) begin
			count_n = '0;
		end else begin
			count_n = body_diff[23:0];
		end
		if (q_entry.last) begin
			tdata_n = {{PAD_W{1'b0}}, count_n, q_entry.header_status,
				q_entry.request_number, q_entry.frame_flags,
				q_entry.frame_type, err, byte_n};
		end else begin
			tdata_n = {{(TDATA_W-8){1'b0}}, byte_n};
		end
	end

	assign q_pop = q_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= tdata_n;
			out_user_q <= q_entry.pay;
			out_last_q <= q_entry.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser || m_tlast)
		else $error("result with neither payload nor verdict");
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
		else $error("payload byte set on a non-payload result");
	a_verdict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[TDATA_W-1:8] == '0)
		else $error("verdict fields set before the final byte");
`endif

endmodule
`default_nettype wire

// ===== rtl/length_prefixed_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Parses length-prefixed frames byte by byte, forwards payload and reports a
// verdict with the header fields on the final byte.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per clock on the s_ side while s_tready is
// high, with s_tlast on the final byte of a frame. Bytes 0-3 carry a
// little-endian body length, bytes 4-19 a header (type, flags, request id,
// status, version, all little-endian); every later byte is forwarded on the
// m_ side with m_tuser set. The final byte produces a result with m_tlast set
// that carries the verdict code and the header fields; on a nonzero code,
// drop the payload already received for that frame. Header and length bytes
// that are not the final byte produce no result. Sustained rate is one byte
// per clock in both directions while m_tready stays high; a result passes
// through the front-to-back queue and the output register before it shows
// up on the m_ side. The queue (QUEUE_DEPTH entries) absorbs output stalls so
// that input flow continues until it fills. Write configuration only while
// no frame is in flight.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser #(
	parameter int unsigned QUEUE_DEPTH = lfp_pkg::QUEUE_DEPTH
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// configuration writes
	input  wire                           cfg_wen,
	input  wire  [lfp_pkg::IDX_W-1:0]     cfg_index,
	input  wire  [lfp_pkg::CFG_W-1:0]     cfg_wdata,
	// frame bytes in
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [7:0]                    s_tdata,   // [7:0] data_byte
	input  wire                           s_tlast,   // last_byte
	// results out
	output logic                          m_tvalid,
	input  wire                           m_tready,
	// [7:0] payload_byte, [10:8] error_code, [26:11] frame_type,
	// [42:27] frame_flags, [74:43] request_number, [106:75] header_status,
	// [130:107] payload_count, rest zero
	output logic [lfp_pkg::TDATA_W-1:0]   m_tdata,
	output logic                          m_tuser,   // payload_valid
	output logic                          m_tlast    // frame_done
);
	import lfp_pkg::*;

	lfp_cfg_t   cfg_q;
	lfp_entry_t push_entry;
	lfp_entry_t pop_entry;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_valid;

	// configuration registers; a write to an unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= 32'd1;
			cfg_q.response_mask    <= 16'd1;
			cfg_q.length_cap       <= 24'd65536;
		end else if (cfg_wen) begin
			case (lfp_reg_e'(cfg_index))
				REG_VERSION:   cfg_q.expected_version <= cfg_wdata[31:0];
				REG_RESP_MASK: cfg_q.response_mask    <= cfg_wdata[15:0];
				REG_LEN_CAP:   cfg_q.length_cap       <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// front: position tracking, header capture, classification
	lfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	// decouple the two sides so each can stall on its own
	lfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.entry_in  (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.entry_out (pop_entry)
	);

	// back: verdict and output register
	lfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_entry  (pop_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
